@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define W3SF_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same, on the block's standard clock and reset names.
`define W3SF_ASSERT_STD(name, prop, msg) \
  `W3SF_ASSERT(name, clk_i, rst_ni, prop, msg)

`endif

@@ hw/rtl/w3sf_pkg.sv @@
package w3sf_pkg;

  localparam int PIX_W      = 8;
  localparam int OUT_ROW_W  = 12;
  localparam int OUT_COL_W  = 11;
  localparam int MODE_W     = 2;
  localparam int IMG_W_W    = 12;
  localparam int IMG_H_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int SUM_W      = 12;

  localparam logic [IMG_W_W-1:0] IMG_W_RST = 12'd640;
  localparam logic [IMG_H_W-1:0] IMG_H_RST = 13'd480;

  // floor(x / 9) == (x * 7282) >> 16 for every 9-tap byte sum
  localparam int MEAN_RECIP_W = 13;
  localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP = 13'd7282;
  localparam int MEAN_SHIFT = 16;
  localparam int GAUSS_SHIFT = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_MEAN   = 2'd0,
    MODE_GAUSS  = 2'd1,
    MODE_MEDIAN = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_MODE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } reg_idx_e;

  // 3x3 window, row-major, element 0 = oldest row / oldest column
  typedef logic [8:0][PIX_W-1:0] win_t;

  // Per-pixel bookkeeping that travels alongside the filter pipeline
  typedef struct packed {
    logic [PIX_W-1:0]     pix;
    logic [OUT_ROW_W-1:0] b_row;
    logic [OUT_COL_W-1:0] b_col;
    logic [OUT_ROW_W-1:0] f_row;
    logic [OUT_COL_W-1:0] f_col;
    logic                 brd;
    logic                 flt;
  } meta_t;

  typedef struct packed {
    logic [PIX_W-1:0]     pixel_out;
    logic [OUT_ROW_W-1:0] out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic                 is_border;
    logic                 last_of_run;
  } res_t;

  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] hi;
  } trio_t;

  function automatic logic [PIX_W-1:0] min2(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max2(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [PIX_W-1:0] med3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                            logic [PIX_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic trio_t sort3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                  logic [PIX_W-1:0] c);
    trio_t t;
    t.lo  = min2(min2(a, b), c);
    t.mid = med3(a, b, c);
    t.hi  = max2(max2(a, b), c);
    return t;
  endfunction

endpackage

@@ hw/rtl/w3sf_if.sv @@
interface w3sf_pix_if;
  import w3sf_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface w3sf_res_if;
  import w3sf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PIX_W-1:0]     pixel_out;
  logic [OUT_ROW_W-1:0] out_row;
  logic [OUT_COL_W-1:0] out_col;
  logic                 is_border;
  logic                 last_of_run;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output is_border, output last_of_run, input ready);
  modport sink   (input valid, input pixel_out, input out_row, input out_col,
                  input is_border, input last_of_run, output ready);
endinterface

interface w3sf_cfg_if;
  import w3sf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/w3sf_kernel.sv @@
module w3sf_kernel (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  w3sf_pkg::win_t              win_i,
  input  w3sf_pkg::meta_t             meta_i,
  input  logic [w3sf_pkg::MODE_W-1:0] mode_i,
  output logic                        valid_o,
  output logic [w3sf_pkg::PIX_W-1:0]  pixel_o,
  output w3sf_pkg::meta_t             meta_o
);
  import w3sf_pkg::*;

  localparam int PROD_W = SUM_W + MEAN_RECIP_W;

  // first stage: sums and per-row sort
  logic [SUM_W-1:0] sum_d, sum_q;
  logic [SUM_W-1:0] gsum_d, gsum_q;
  trio_t [2:0]      rows_d, rows_q;
  meta_t            meta3_q;
  logic             v3_q;

  // second stage: scaled linear result and median candidates
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  lin_d, lin_q;
  logic [PIX_W-1:0]  maxlo_d, maxlo_q, medmid_d, medmid_q, minhi_d, minhi_q;
  meta_t             meta4_q;
  logic              v4_q;

  always_comb begin
    sum_d = SUM_W'(win_i[0]) + SUM_W'(win_i[1]) + SUM_W'(win_i[2])
          + SUM_W'(win_i[3]) + SUM_W'(win_i[4]) + SUM_W'(win_i[5])
          + SUM_W'(win_i[6]) + SUM_W'(win_i[7]) + SUM_W'(win_i[8]);
    gsum_d = SUM_W'(win_i[0]) + (SUM_W'(win_i[1]) << 1) + SUM_W'(win_i[2])
           + (SUM_W'(win_i[3]) << 1) + (SUM_W'(win_i[4]) << 2) + (SUM_W'(win_i[5]) << 1)
           + SUM_W'(win_i[6]) + (SUM_W'(win_i[7]) << 1) + SUM_W'(win_i[8]);
    for (int i = 0; i < 3; i++) begin
      rows_d[i] = sort3(win_i[3*i], win_i[3*i+1], win_i[3*i+2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q   <= sum_d;
      gsum_q  <= gsum_d;
      rows_q  <= rows_d;
      meta3_q <= meta_i;
    end
  end

  always_comb begin
    prod     = PROD_W'(sum_q) * PROD_W'(MEAN_RECIP);
    lin_d    = (mode_i == MODE_MEAN) ? prod[MEAN_SHIFT +: PIX_W]
                                     : gsum_q[GAUSS_SHIFT +: PIX_W];
    maxlo_d  = max2(max2(rows_q[0].lo, rows_q[1].lo), rows_q[2].lo);
    medmid_d = med3(rows_q[0].mid, rows_q[1].mid, rows_q[2].mid);
    minhi_d  = min2(min2(rows_q[0].hi, rows_q[1].hi), rows_q[2].hi);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lin_q    <= lin_d;
      maxlo_q  <= maxlo_d;
      medmid_q <= medmid_d;
      minhi_q  <= minhi_d;
      meta4_q  <= meta3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  // unused mode code falls to the median
  assign pixel_o = (mode_i == MODE_MEAN || mode_i == MODE_GAUSS) ? lin_q
                 : med3(maxlo_q, medmid_q, minhi_q);
  assign meta_o  = meta4_q;
  assign valid_o = v4_q;

endmodule

@@ hw/rtl/window3x3_smoothing_filter.sv @@
// Channel   Dir  Beat contents                                  Accept
// pix_i     in   pixel_in[7:0]                                  valid & ready
// res_o     out  pixel_out, out_row, out_col, is_border, last   valid & ready
// cfg_i     in   index[1:0] (0 mode, 1 width, 2 height), data    valid & ready
//
// One pixel per cycle sustained while the output accepts; a pixel that
// yields both a border and a filtered beat holds the input while the second
// beat drains. Results pass the stage 1, window, kernel and output registers.
// Line store is a single-port-write, single-read RAM (registered read); it has
// no clearing pass and is usable right after reset.
// Input stalls only while the output register still holds a beat that
// cannot move; the whole pipe advances on one enable.
module window3x3_smoothing_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  w3sf_pix_if.sink   pix_i,
  w3sf_res_if.source res_o,
  w3sf_cfg_if.sink   cfg_i
);
  import w3sf_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);       // column index / RAM address
  localparam int WW = $clog2(MAX_WIDTH + 1);   // effective width
  localparam int RW = $clog2(MAX_HEIGHT);      // row index
  localparam int HW = $clog2(MAX_HEIGHT + 1);  // effective height
  localparam int LW = 2 * PIX_W;               // RAM word: {row r-2, row r-1}

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [MODE_W-1:0]  mode_q;
  logic [IMG_W_W-1:0] img_w_q;
  logic [IMG_H_W-1:0] img_h_q;
  logic               cfg_fire;
  logic               geo_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign geo_wr      = cfg_fire && (cfg_i.index == REG_IMAGE_WIDTH ||
                                    cfg_i.index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_MEAN;
      img_w_q <= IMG_W_RST;
      img_h_q <= IMG_H_RST;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        REG_FILTER_MODE:  mode_q  <= cfg_i.data[MODE_W-1:0];
        REG_IMAGE_WIDTH:  img_w_q <= cfg_i.data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: img_h_q <= cfg_i.data;
        default: ;  // write outside the register list: drop
      endcase
    end
  end

  // Clamp geometry: zero acts as one, oversize as the maximum
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  always_comb begin
    if (img_w_q == '0) begin
      eff_w = WW'(1);
    end else if (int'(img_w_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(img_w_q);
    end
    if (img_h_q == '0) begin
      eff_h = HW'(1);
    end else if (int'(img_h_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(img_h_q);
    end
  end

  // ---------------------------------------------------------------------
  // Pipe enable: advance when the output register is free or frees now
  // ---------------------------------------------------------------------
  logic [1:0] out_cnt_q;
  logic       en;
  logic       in_fire;
  logic       out_fire;

  assign en          = (out_cnt_q == 2'd0) || (out_cnt_q == 2'd1 && res_o.ready);
  assign pix_i.ready = en;
  assign in_fire     = pix_i.valid && en;
  assign out_fire    = res_o.valid && res_o.ready;

  // ---------------------------------------------------------------------
  // Stage 0: position counters, border / interior decode, RAM read
  // ---------------------------------------------------------------------
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [WW-1:0] col_p1;
  logic [HW-1:0] row_p1;
  logic          end_of_row, end_of_frame;
  meta_t         s0_meta;

  assign col_p1       = WW'(col_q) + WW'(1);
  assign row_p1       = HW'(row_q) + HW'(1);
  assign end_of_row   = (col_p1 == eff_w);
  assign end_of_frame = (row_p1 == eff_h);

  always_comb begin
    s0_meta.pix   = pix_i.pixel_in;
    s0_meta.b_row = OUT_ROW_W'(row_q);
    s0_meta.b_col = OUT_COL_W'(col_q);
    s0_meta.f_row = OUT_ROW_W'(row_q - RW'(1));
    s0_meta.f_col = OUT_COL_W'(col_q - AW'(1));
    s0_meta.brd   = (row_q == '0) || (col_q == '0) || end_of_frame || end_of_row;
    s0_meta.flt   = (row_q >= RW'(2)) && (col_q >= AW'(2));
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (geo_wr) begin
      // geometry change restarts the frame
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (end_of_row) begin
        col_d = '0;
        row_d = end_of_frame ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: RAM data back, window shift, write-back of the column
  // ---------------------------------------------------------------------
  logic [LW-1:0] lbuf_q [MAX_WIDTH];
  logic [LW-1:0] rdata_q;
  logic [LW-1:0] fwd_data_q;
  logic          fwd_q;
  logic          s1_valid_q;
  logic [AW-1:0] s1_addr_q;
  meta_t         s1_meta_q;
  logic [LW-1:0] col_word;
  logic [PIX_W-1:0] above1, above2;
  logic [LW-1:0] wr_word;
  logic          wr_en;
  logic          fwd_hit;

  // same column written and read on one edge for one-pixel rows, or after a
  // geometry restart under a stall; bypass the RAM then
  assign col_word = fwd_q ? fwd_data_q : rdata_q;
  assign above1   = col_word[PIX_W-1:0];
  assign above2   = col_word[LW-1:PIX_W];
  assign wr_word  = {above1, s1_meta_q.pix};
  assign wr_en    = en && s1_valid_q;
  assign fwd_hit  = wr_en && (s1_addr_q == col_q);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rdata_q <= lbuf_q[col_q];
    end
    if (wr_en) begin
      lbuf_q[s1_addr_q] <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fwd_data_q <= wr_word;
      s1_addr_q  <= col_q;
      s1_meta_q  <= s0_meta;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= pix_i.valid;
      if (in_fire) begin
        fwd_q <= fwd_hit;
      end
    end
  end

  // Window: shift left, insert {row r-2, row r-1, row r} as newest column
  win_t  win_q, win_d;
  logic  s2_valid_q;
  meta_t s2_meta_q;

  always_comb begin
    win_d    = win_q;
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = above2;
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = above1;
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = s1_meta_q.pix;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_q     <= win_d;
      s2_meta_q <= s1_meta_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 2..4: filter arithmetic
  // ---------------------------------------------------------------------
  logic             k_valid;
  logic [PIX_W-1:0] k_pix;
  meta_t            k_meta;

  w3sf_kernel u_kernel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_valid_q),
    .win_i   (win_q),
    .meta_i  (s2_meta_q),
    .mode_i  (mode_q),
    .valid_o (k_valid),
    .pixel_o (k_pix),
    .meta_o  (k_meta)
  );

  // ---------------------------------------------------------------------
  // Output register: up to two beats per pixel, border beat first
  // ---------------------------------------------------------------------
  res_t slot0_q, slot1_q;
  res_t brd_res, flt_res;
  logic load;

  always_comb begin
    brd_res.pixel_out   = k_meta.pix;
    brd_res.out_row     = k_meta.b_row;
    brd_res.out_col     = k_meta.b_col;
    brd_res.is_border   = 1'b1;
    brd_res.last_of_run = !k_meta.flt;
    flt_res.pixel_out   = k_pix;
    flt_res.out_row     = k_meta.f_row;
    flt_res.out_col     = k_meta.f_col;
    flt_res.is_border   = 1'b0;
    flt_res.last_of_run = 1'b1;
  end

  assign load = en && k_valid && (k_meta.brd || k_meta.flt);

  always_ff @(posedge clk_i) begin
    if (load) begin
      slot0_q <= k_meta.brd ? brd_res : flt_res;
      slot1_q <= flt_res;
    end else if (out_fire) begin
      slot0_q <= slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= 2'd0;
    end else if (load) begin
      out_cnt_q <= 2'(k_meta.brd) + 2'(k_meta.flt);
    end else if (out_fire) begin
      out_cnt_q <= out_cnt_q - 2'd1;
    end
  end

  assign res_o.valid       = (out_cnt_q != 2'd0);
  assign res_o.pixel_out   = slot0_q.pixel_out;
  assign res_o.out_row     = slot0_q.out_row;
  assign res_o.out_col     = slot0_q.out_col;
  assign res_o.is_border   = slot0_q.is_border;
  assign res_o.last_of_run = slot0_q.last_of_run;

endmodule

@@ hw/rtl/w3sf_checker.sv @@
`include "assert_macros.svh"

module w3sf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_i,
  input logic                           res_valid_i,
  input logic                           res_ready_i,
  input logic [w3sf_pkg::PIX_W-1:0]     res_pixel_i,
  input logic [w3sf_pkg::OUT_ROW_W-1:0] res_row_i,
  input logic [w3sf_pkg::OUT_COL_W-1:0] res_col_i,
  input logic                           res_border_i,
  input logic                           res_last_i
);
  import w3sf_pkg::*;

  // a non-final beat is always followed by its partner beat
  `W3SF_ASSERT_STD(a_pair_follows, res_valid_i && res_ready_i && !res_last_i |=> res_valid_i, "second beat of a pair missing")

  // only a border beat can lead a pair; filtered beats close the run
  `W3SF_ASSERT_STD(a_filtered_is_last, res_valid_i && !res_border_i |-> res_last_i, "filtered beat not marked last")

  // input is held back only while a result waits
  `W3SF_ASSERT_STD(a_stall_has_cause, !in_ready_i |-> res_valid_i, "input stalled with no pending result")

  // stalled result beat holds
  `W3SF_ASSERT_STD(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_pixel_i) && $stable(res_row_i) && $stable(res_col_i) && $stable(res_border_i) && $stable(res_last_i), "stalled result beat changed")

endmodule

bind window3x3_smoothing_filter w3sf_checker u_w3sf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (pix_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_pixel_i  (res_o.pixel_out),
  .res_row_i    (res_o.out_row),
  .res_col_i    (res_o.out_col),
  .res_border_i (res_o.is_border),
  .res_last_i   (res_o.last_of_run)
);

@@ sim/window3x3_smoothing_filter_tb.sv @@
`timescale 1ns / 100ps

module window3x3_smoothing_filter_tb;
  import w3sf_pkg::*;

  localparam int MAX_W         = 2048;
  localparam int MAX_H         = 4096;
  // Room for pixels that cause no beat to clear the pipe
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int RANDOM_PIXELS = 650;
  // Selector value with no filter of its own; the block treats it as median
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  w3sf_pix_if pix_if ();
  w3sf_res_if res_if ();
  w3sf_cfg_if cfg_if ();

  window3x3_smoothing_filter #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the filter: registers, line stores, window and position
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]  mode_sh   = MODE_MEAN;
  logic [IMG_W_W-1:0] width_sh  = IMG_W_RST;
  logic [IMG_H_W-1:0] height_sh = IMG_H_RST;
  // Lower half holds row r-1, upper half row r-2
  logic [PIX_W-1:0]   line_mem [2*MAX_W];
  // Row-major 3x3 window, column 2 is the newest
  logic [PIX_W-1:0]   window_px [9];
  int unsigned        next_col = 0;
  int unsigned        next_row = 0;

  logic [PIX_W-1:0] pending_pixels [$];
  res_t             expected_results [$];
  int unsigned      pixels_queued  = 0;
  int unsigned      pixels_taken   = 0;
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      error_count    = 0;
  int unsigned      cycle_count    = 0;
  res_t             want_beat;

  // Zero means one; anything past the store size saturates at it
  function automatic int unsigned clamp_size(int unsigned v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] smooth_window();
    int unsigned      acc;
    logic [PIX_W-1:0] srt [9];
    logic [PIX_W-1:0] tmp;
    acc = 0;
    if (mode_sh == MODE_MEAN) begin
      foreach (window_px[i]) acc += 32'(window_px[i]);
      return PIX_W'(acc / 9);
    end
    if (mode_sh == MODE_GAUSS) begin
      acc = 32'(window_px[0]) + 2 * 32'(window_px[1]) + 32'(window_px[2])
          + 2 * 32'(window_px[3]) + 4 * 32'(window_px[4]) + 2 * 32'(window_px[5])
          + 32'(window_px[6]) + 2 * 32'(window_px[7]) + 32'(window_px[8]);
      return PIX_W'(acc >> 4);
    end
    // Median and the spare selector: fifth smallest of nine
    srt = window_px;
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8 - i; j++)
        if (srt[j] > srt[j+1]) begin
          tmp      = srt[j];
          srt[j]   = srt[j+1];
          srt[j+1] = tmp;
        end
    return srt[4];
  endfunction

  // Advance the shadow by one accepted pixel and queue the beats it causes
  function automatic void predict_pixel(logic [PIX_W-1:0] pix);
    int unsigned      w, h, r, c;
    logic [PIX_W-1:0] above1, above2;
    logic             brd, flt;
    res_t             beat;
    w = clamp_size(width_sh, MAX_W);
    h = clamp_size(height_sh, MAX_H);
    r = next_row;
    c = next_col;
    above1 = line_mem[c];
    above2 = line_mem[MAX_W + c];

    window_px[0] = window_px[1];
    window_px[1] = window_px[2];
    window_px[3] = window_px[4];
    window_px[4] = window_px[5];
    window_px[6] = window_px[7];
    window_px[7] = window_px[8];
    window_px[2] = above2;
    window_px[5] = above1;
    window_px[8] = pix;

    line_mem[MAX_W + c] = above1;
    line_mem[c]         = pix;

    brd = (r == 0) || (c == 0) || (r + 1 >= h) || (c + 1 >= w);
    flt = (r >= 2) && (c >= 2);

    // Border pass-through goes first, the filtered centre after it
    if (brd) begin
      beat.pixel_out   = pix;
      beat.out_row     = OUT_ROW_W'(r);
      beat.out_col     = OUT_COL_W'(c);
      beat.is_border   = 1'b1;
      beat.last_of_run = !flt;
      expected_results = {expected_results, beat};
    end
    if (flt) begin
      beat.pixel_out   = smooth_window();
      beat.out_row     = OUT_ROW_W'(r - 1);
      beat.out_col     = OUT_COL_W'(c - 1);
      beat.is_border   = 1'b0;
      beat.last_of_run = 1'b1;
      expected_results = {expected_results, beat};
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
  endfunction

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    // Lean on the extremes so sums hit their limits often
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Mostly small frames, some medium, a few degenerate (zero reads as one)
  function automatic int unsigned pick_size();
    case ($urandom_range(9))
      0:       return $urandom_range(2);
      1, 2:    return $urandom_range(24, 9);
      default: return $urandom_range(8, 3);
    endcase
  endfunction

  task automatic push_pixel(logic [PIX_W-1:0] pix);
    pending_pixels = {pending_pixels, pix};
    pixels_queued++;
  endtask

  // Write one register; apply it to the shadow once the beat is taken
  task automatic write_reg(reg_idx_e idx, int unsigned value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_DATA_W'(value);
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_FILTER_MODE: mode_sh = MODE_W'(value);
      REG_IMAGE_WIDTH: begin
        width_sh = IMG_W_W'(value);
        next_col = 0;
        next_row = 0;
      end
      REG_IMAGE_HEIGHT: begin
        height_sh = IMG_H_W'(value);
        next_col  = 0;
        next_row  = 0;
      end
      default: ;
    endcase
  endtask

  // Hold until every queued pixel is taken and every expected beat is back,
  // then let pixels that cause no beat clear the pipe
  task automatic wait_idle();
    while (pixels_taken != pixels_queued || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver: present the next pending pixel, hold it until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_if.valid    <= 1'b0;
      pix_if.pixel_in <= '0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        predict_pixel(pix_if.pixel_in);
        pixels_taken++;
      end
      // Only move on once the current beat is gone
      if (!pix_if.valid || pix_if.ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pix_if.valid    <= 1'b1;
          pix_if.pixel_in <= pending_pixels.pop_front();
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: stall at random, check each beat against the oldest
  // expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: row %0d col %0d pixel %0d",
                 res_if.out_row, res_if.out_col, res_if.pixel_out);
          error_count++;
        end else begin
          want_beat = expected_results.pop_front();
          check_field("pixel_out", 16'(want_beat.pixel_out), 16'(res_if.pixel_out));
          check_field("out_row", 16'(want_beat.out_row), 16'(res_if.out_row));
          check_field("out_col", 16'(want_beat.out_col), 16'(res_if.out_col));
          check_field("is_border", 16'(want_beat.is_border), 16'(res_if.is_border));
          check_field("last_of_run", 16'(want_beat.last_of_run),
                      16'(res_if.last_of_run));
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned phase;

    // Known values on the configuration inputs from time zero
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_FILTER_MODE;
    cfg_if.data     = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: smallest full frame, checkerboard through the mean
    write_reg(REG_FILTER_MODE, MODE_MEAN);
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 3);
    for (int i = 0; i < 9; i++) push_pixel((i % 2 != 0) ? 8'h00 : 8'hFF);
    wait_idle();

    // Saturated frame through the Gaussian: largest weighted sum
    write_reg(REG_FILTER_MODE, MODE_GAUSS);
    repeat (9) push_pixel(8'hFF);
    wait_idle();

    // Tiny frame: zero width reads as one column, everything passes through
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 2);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    wait_idle();

    // Random phases; rotate the idling pattern, frames often straddle phases
    // and geometry writes land mid-frame
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_PIXELS) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if ($urandom_range(2) != 0)
        write_reg(REG_FILTER_MODE, $urandom_range(MODE_SPARE));
      if (phase == 0 || $urandom_range(3) == 0) begin
        write_reg(REG_IMAGE_WIDTH, pick_size());
        write_reg(REG_IMAGE_HEIGHT, pick_size());
      end else if ($urandom_range(5) == 0) begin
        write_reg(REG_IMAGE_HEIGHT, pick_size());
      end
      n = $urandom_range(60, 10);
      repeat (n) push_pixel(rand_pixel());
      sent += n;
      // Pause the sender until everything is back before the next phase
      wait_idle();
      phase++;
    end

    // One column, height past the limit: every pixel passes through
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_FILTER_MODE, MODE_SPARE);
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, (1 << IMG_H_W) - 1);
    repeat (40) push_pixel(rand_pixel());
    wait_idle();

    // Width past the limit, full height: first row only
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    write_reg(REG_IMAGE_WIDTH, (1 << IMG_W_W) - 1);
    write_reg(REG_IMAGE_HEIGHT, MAX_H);
    repeat (40) push_pixel(rand_pixel());
    wait_idle();

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/w3sf_pkg.sv
hw/rtl/w3sf_if.sv
hw/rtl/w3sf_kernel.sv
hw/rtl/window3x3_smoothing_filter.sv
hw/rtl/w3sf_checker.sv
sim/window3x3_smoothing_filter_tb.sv
